### src/radial_brush_falloff_mask_unit_macros.svh
// Assertion macros used by the checker of the radial brush falloff mask unit.
`ifndef RADIAL_BRUSH_FALLOFF_MASK_UNIT_MACROS_SVH
`define RADIAL_BRUSH_FALLOFF_MASK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBFM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBFM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rbfm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and types of the radial brush falloff mask unit.
package rbfm_pkg;

   localparam int IDX_W       = 14;
   localparam int RADIUS_W    = 6;
   localparam int KIND_W      = 2;
   localparam int SIDE_W      = RADIUS_W + 1;
   localparam int AREA_W      = 2 * SIDE_W;
   localparam int RR_W        = 2 * RADIUS_W;
   localparam int DIST_W      = RR_W + 1;
   localparam int FRAC_W      = 16;
   localparam int ROOT_W      = (DIST_W + 1) / 2 + FRAC_W;
   localparam int RFX_W       = RADIUS_W + FRAC_W;
   localparam int NSQ_W       = 2 * RFX_W;
   localparam int NUM_W       = NSQ_W - FRAC_W;
   localparam int OPACITY_W   = FRAC_W + 1;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = RADIUS_W;
   localparam int DIV_STEPS   = 4;
   localparam int SQRT_STEPS  = 4;

   localparam logic [OPACITY_W-1:0] OPACITY_ONE = OPACITY_W'(1) << FRAC_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_CONSTANT  = 2'd0,
      KIND_LINEAR    = 2'd1,
      KIND_QUADRATIC = 2'd2
   } falloff_kind_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BRUSH_RADIUS = 1'b0,
      CSR_FALLOFF_KIND = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic out_of_range;
      logic in_disc;
      logic in_reach;
   } item_flags_type;

endpackage

### src/rbfm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider with a tag that travels alongside each request.
module rbfm_div #(
   parameter int DVD_W = 14,
   parameter int DVS_W = 7,
   parameter int Q_W   = 7,
   parameter int STEPS = 4,
   parameter int TAG_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [DVD_W-1:0] in_dividend,
   input  logic [DVS_W-1:0] in_divisor,
   input  logic [TAG_W-1:0] in_tag,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [Q_W-1:0]   out_quotient,
   output logic [DVS_W-1:0] out_remainder,
   output logic [TAG_W-1:0] out_tag
);
   localparam int NST = (Q_W + STEPS - 1) / STEPS;
   localparam int CW  = (DVD_W > DVS_W + Q_W) ? DVD_W : DVS_W + Q_W;

   logic [NST-1:0]   valid_ff;
   logic [NST:0]     valid_chain;
   logic [NST:0]     enable;
   logic [CW-1:0]    rem_ff   [NST];
   logic [Q_W-1:0]   quot_ff  [NST];
   logic [DVS_W-1:0] dvs_ff   [NST];
   logic [TAG_W-1:0] tag_ff   [NST];
   logic [CW-1:0]    rem_src  [NST];
   logic [Q_W-1:0]   quot_src [NST];
   logic [DVS_W-1:0] dvs_src  [NST];
   logic [TAG_W-1:0] tag_src  [NST];

   // A stage takes new content when it is empty or its content moves on.
   always_comb begin
      enable[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         enable[k] = !valid_ff[k] || enable[k+1];
      end
   end

   assign valid_chain = {valid_ff, in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (enable[k]) begin
               valid_ff[k] <= valid_chain[k];
            end
         end
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_stage
      logic [CW-1:0]  rem_in;
      logic [Q_W-1:0] quot_in;

      if (k == 0) begin : g_head
         assign rem_src[k]  = CW'(in_dividend);
         assign quot_src[k] = '0;
         assign dvs_src[k]  = in_divisor;
         assign tag_src[k]  = in_tag;
      end else begin : g_body
         assign rem_src[k]  = rem_ff[k-1];
         assign quot_src[k] = quot_ff[k-1];
         assign dvs_src[k]  = dvs_ff[k-1];
         assign tag_src[k]  = tag_ff[k-1];
      end

      // Each stage resolves up to STEPS quotient bits, most significant first.
      always_comb begin
         logic [CW-1:0]  rem_v;
         logic [Q_W-1:0] quot_v;
         logic [CW-1:0]  trial;
         rem_v  = rem_src[k];
         quot_v = quot_src[k];
         trial  = '0;
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < Q_W) begin
               trial = CW'(dvs_src[k]) << (Q_W - 1 - (k * STEPS + j));
               if (rem_v >= trial) begin
                  rem_v = rem_v - trial;
                  quot_v[Q_W-1-(k*STEPS+j)] = 1'b1;
               end
            end
         end
         rem_in  = rem_v;
         quot_in = quot_v;
      end

      always_ff @(posedge clock) begin
         if (enable[k]) begin
            rem_ff[k]  <= rem_in;
            quot_ff[k] <= quot_in;
            dvs_ff[k]  <= dvs_src[k];
            tag_ff[k]  <= tag_src[k];
         end
      end
   end

   assign in_ready      = enable[0];
   assign out_valid     = valid_ff[NST-1];
   assign out_quotient  = quot_ff[NST-1];
   assign out_remainder = rem_ff[NST-1][DVS_W-1:0];
   assign out_tag       = tag_ff[NST-1];

endmodule

### src/rbfm_isqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of a value scaled by 2 to the 2*FRAC_W.
module rbfm_isqrt #(
   parameter int IN_W   = 13,
   parameter int FRAC_W = 16,
   parameter int STEPS  = 4,
   parameter int TAG_W  = 3,
   localparam int ROOT_W = (IN_W + 1) / 2 + FRAC_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [IN_W-1:0]   in_value,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_root,
   output logic [TAG_W-1:0]  out_tag
);
   localparam int HALF  = (IN_W + 1) / 2;
   localparam int XP_W  = 2 * HALF;
   localparam int REM_W = ROOT_W + 2;
   localparam int NST   = (ROOT_W + STEPS - 1) / STEPS;

   logic [NST-1:0]    valid_ff;
   logic [NST:0]      valid_chain;
   logic [NST:0]      enable;
   logic [XP_W-1:0]   val_ff   [NST];
   logic [REM_W-1:0]  rem_ff   [NST];
   logic [ROOT_W-1:0] root_ff  [NST];
   logic [TAG_W-1:0]  tag_ff   [NST];
   logic [XP_W-1:0]   val_src  [NST];
   logic [REM_W-1:0]  rem_src  [NST];
   logic [ROOT_W-1:0] root_src [NST];
   logic [TAG_W-1:0]  tag_src  [NST];

   always_comb begin
      enable[NST] = out_ready;
      for (int k = NST - 1; k >= 0; k--) begin
         enable[k] = !valid_ff[k] || enable[k+1];
      end
   end

   assign valid_chain = {valid_ff, in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (enable[k]) begin
               valid_ff[k] <= valid_chain[k];
            end
         end
      end
   end

   for (genvar k = 0; k < NST; k++) begin : g_stage
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (k == 0) begin : g_head
         assign val_src[k]  = XP_W'(in_value);
         assign rem_src[k]  = '0;
         assign root_src[k] = '0;
         assign tag_src[k]  = in_tag;
      end else begin : g_body
         assign val_src[k]  = val_ff[k-1];
         assign rem_src[k]  = rem_ff[k-1];
         assign root_src[k] = root_ff[k-1];
         assign tag_src[k]  = tag_ff[k-1];
      end

      // The low FRAC_W bit pairs of the scaled radicand are all zero.
      always_comb begin
         logic [REM_W-1:0]  rem_v;
         logic [ROOT_W-1:0] root_v;
         logic [REM_W-1:0]  trial;
         logic [1:0]        pair;
         int                p;
         rem_v  = rem_src[k];
         root_v = root_src[k];
         trial  = '0;
         pair   = '0;
         p      = 0;
         for (int j = 0; j < STEPS; j++) begin
            if (k * STEPS + j < ROOT_W) begin
               p = ROOT_W - 1 - (k * STEPS + j);
               if (p >= FRAC_W) begin
                  pair = val_src[k][2*(p-FRAC_W) +: 2];
               end else begin
                  pair = 2'b00;
               end
               rem_v = (rem_v << 2) | REM_W'(pair);
               trial = (REM_W'(root_v) << 2) | REM_W'(1);
               if (rem_v >= trial) begin
                  rem_v  = rem_v - trial;
                  root_v = {root_v[ROOT_W-2:0], 1'b1};
               end else begin
                  root_v = {root_v[ROOT_W-2:0], 1'b0};
               end
            end
         end
         rem_in  = rem_v;
         root_in = root_v;
      end

      always_ff @(posedge clock) begin
         if (enable[k]) begin
            val_ff[k]  <= val_src[k];
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            tag_ff[k]  <= tag_src[k];
         end
      end
   end

   assign in_ready  = enable[0];
   assign out_valid = valid_ff[NST-1];
   assign out_root  = root_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule

### src/radial_brush_falloff_mask_unit.sv
`timescale 1ns / 1ps
// Top level of the radial brush falloff mask unit: opacity of one brush mask cell.
//
//   Port group  Direction  Contents
//   req_*       in         cell index, one request per cycle while req_tready
//   rsp_*       out        opacity (16 fraction bits) and out-of-range flag
//   csr_*       in         brush radius and falloff kind writes
//
// One request is accepted per cycle while no stall holds the pipeline; the result passes
// through 3 local stages, 2 for the row/column split, 6 for the square root of the
// distance and 5 for the final quotient, each resolving up to four digits per stage.
// Reset is synchronous and clears all valid bits and both configuration registers.
// When the result side stalls, each stage holds until the next one frees up,
// and empty stages keep filling, so no request is dropped or repeated.
module radial_brush_falloff_mask_unit #(
   parameter int MAX_RADIUS = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rbfm_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [13:0] cell_index
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rbfm_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [16:0] opacity
   output logic                                rsp_tuser,   // [0] index_out_of_range
   input  logic                                csr_we,
   input  logic [rbfm_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rbfm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rbfm_pkg::*;

   localparam int RADIUS_TOP = (1 << RADIUS_W) - 1;
   localparam int RMAX_CLIP  = (MAX_RADIUS < RADIUS_TOP) ? MAX_RADIUS : RADIUS_TOP;
   localparam logic [RADIUS_W-1:0] RMAX = RADIUS_W'(RMAX_CLIP);

   // Configuration.
   logic [RADIUS_W-1:0] radius_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [SIDE_W-1:0]   mask_side;
   logic [AREA_W-1:0]   mask_area;
   logic [RR_W-1:0]     radius_sq;

   // Entry stage.
   logic               s0_valid_ff;
   logic [IDX_W-1:0]   s0_index_ff;
   logic               s0_oor_ff;
   logic               s0_oor_in;
   logic               s0_enable;

   // Row and column split.
   logic               div1_ready;
   logic               rc_valid;
   logic [SIDE_W-1:0]  rc_row;
   logic [SIDE_W-1:0]  rc_col;
   logic               rc_oor;

   // Distance stage.
   logic                dist_valid_ff;
   logic [DIST_W-1:0]   dist_ff;
   item_flags_type      dist_flags_ff;
   logic [DIST_W-1:0]   dist_in;
   item_flags_type      dist_flags_in;
   logic [RADIUS_W-1:0] dy;
   logic [RADIUS_W-1:0] dx;
   logic                dist_enable;

   // Square root.
   logic                sqrt_ready;
   logic                sq_valid;
   logic [ROOT_W-1:0]   sq_root;
   item_flags_type      sq_flags;

   // Numerator stage.
   logic                num_valid_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [RR_W-1:0]     den_ff;
   logic                num_oor_ff;
   logic [NUM_W-1:0]    num_in;
   logic [RR_W-1:0]     den_in;
   logic [RFX_W-1:0]    radius_fx;
   logic                beyond_edge;
   logic [RFX_W-1:0]    edge_gap;
   logic [NSQ_W-1:0]    gap_sq;
   logic                num_enable;

   // Final quotient.
   logic                div2_ready;
   logic [OPACITY_W-1:0] opacity;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
         kind_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BRUSH_RADIUS: radius_ff <= (csr_wdata > RMAX) ? RMAX : csr_wdata;
            CSR_FALLOFF_KIND: kind_ff   <= csr_wdata[KIND_W-1:0];
         endcase
      end
   end

   assign mask_side = {radius_ff, 1'b1};
   assign mask_area = AREA_W'(mask_side) * AREA_W'(mask_side);
   assign radius_sq = RR_W'(radius_ff) * RR_W'(radius_ff);

   // Entry stage: range check against the mask area.
   assign s0_enable  = !s0_valid_ff || div1_ready;
   assign req_tready = s0_enable;
   assign s0_oor_in  = req_tdata[IDX_W-1:0] >= mask_area;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_enable) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_enable) begin
         s0_index_ff <= req_tdata[IDX_W-1:0];
         s0_oor_ff   <= s0_oor_in;
      end
   end

   rbfm_div #(
      .DVD_W (IDX_W),
      .DVS_W (SIDE_W),
      .Q_W   (SIDE_W),
      .STEPS (DIV_STEPS),
      .TAG_W (1)
   ) u_rowcol_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s0_valid_ff),
      .in_ready      (div1_ready),
      .in_dividend   (s0_index_ff),
      .in_divisor    (mask_side),
      .in_tag        (s0_oor_ff),
      .out_valid     (rc_valid),
      .out_ready     (dist_enable),
      .out_quotient  (rc_row),
      .out_remainder (rc_col),
      .out_tag       (rc_oor)
   );

   // Distance stage: squared distance from the centre cell.
   always_comb begin
      logic [SIDE_W-1:0] rad_ext;
      rad_ext = SIDE_W'(radius_ff);
      dy = (rc_row >= rad_ext) ? RADIUS_W'(rc_row - rad_ext) : RADIUS_W'(rad_ext - rc_row);
      dx = (rc_col >= rad_ext) ? RADIUS_W'(rc_col - rad_ext) : RADIUS_W'(rad_ext - rc_col);
      dist_in = DIST_W'(RR_W'(dy) * RR_W'(dy)) + DIST_W'(RR_W'(dx) * RR_W'(dx));
      dist_flags_in.out_of_range = rc_oor;
      dist_flags_in.in_disc      = dist_in < DIST_W'(radius_sq);
      dist_flags_in.in_reach     = dist_in <= DIST_W'(radius_sq);
   end

   assign dist_enable = !dist_valid_ff || sqrt_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_valid_ff <= 1'b0;
      end else if (dist_enable) begin
         dist_valid_ff <= rc_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_enable) begin
         dist_ff       <= dist_in;
         dist_flags_ff <= dist_flags_in;
      end
   end

   rbfm_isqrt #(
      .IN_W   (DIST_W),
      .FRAC_W (FRAC_W),
      .STEPS  (SQRT_STEPS),
      .TAG_W  ($bits(item_flags_type))
   ) u_dist_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_valid_ff),
      .in_ready  (sqrt_ready),
      .in_value  (dist_ff),
      .in_tag    (dist_flags_ff),
      .out_valid (sq_valid),
      .out_ready (num_enable),
      .out_root  (sq_root),
      .out_tag   (sq_flags)
   );

   // Numerator stage: every falloff ends as one quotient; fixed answers divide by one.
   assign radius_fx   = {radius_ff, FRAC_W'(0)};
   assign beyond_edge = sq_root >= ROOT_W'(radius_fx);
   assign edge_gap    = radius_fx - sq_root[RFX_W-1:0];
   assign gap_sq      = NSQ_W'(edge_gap) * NSQ_W'(edge_gap);

   always_comb begin
      num_in = '0;
      den_in = RR_W'(1);
      priority if (sq_flags.out_of_range) begin
         num_in = '0;
      end else if (radius_ff == '0) begin
         num_in = NUM_W'(OPACITY_ONE);
      end else begin
         unique case (kind_ff)
            KIND_CONSTANT: begin
               num_in = sq_flags.in_disc ? NUM_W'(OPACITY_ONE) : '0;
            end
            KIND_LINEAR: begin
               if (!beyond_edge) begin
                  num_in = NUM_W'(edge_gap);
                  den_in = RR_W'(radius_ff);
               end
            end
            default: begin
               // Quadratic; the unused selector code falls here too.
               if (sq_flags.in_reach) begin
                  num_in = gap_sq[NSQ_W-1:FRAC_W];
                  den_in = radius_sq;
               end
            end
         endcase
      end
   end

   assign num_enable = !num_valid_ff || div2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (num_enable) begin
         num_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (num_enable) begin
         num_ff     <= num_in;
         den_ff     <= den_in;
         num_oor_ff <= sq_flags.out_of_range;
      end
   end

   rbfm_div #(
      .DVD_W (NUM_W),
      .DVS_W (RR_W),
      .Q_W   (OPACITY_W),
      .STEPS (DIV_STEPS),
      .TAG_W (1)
   ) u_opacity_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (num_valid_ff),
      .in_ready      (div2_ready),
      .in_dividend   (num_ff),
      .in_divisor    (den_ff),
      .in_tag        (num_oor_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_quotient  (opacity),
      .out_remainder (),
      .out_tag       (rsp_tuser)
   );

   assign rsp_tdata = RSP_TDATA_W'(opacity);

endmodule

### src/rbfm_check.sv
`timescale 1ns / 1ps
// Port-level checker of the radial brush falloff mask unit and its bind.
`include "radial_brush_falloff_mask_unit_macros.svh"

module rbfm_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rbfm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);
   import rbfm_pkg::*;

   // Reset empties the whole pipeline.
   `RBFM_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // With nothing at the output, no stage can be blocked.
   `RBFM_ASSERT_IMPLY(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready, "request refused while output empty")

   // A refused result stays put.
   `RBFM_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // An index past the mask always reads as fully transparent.
   `RBFM_ASSERT_IMPLY(a_oor_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[OPACITY_W-1:0] == '0, "out of range with nonzero opacity")

   // Opacity never exceeds one and the padding bits stay clear.
   `RBFM_ASSERT_IMPLY(a_opacity_range, clock, reset, rsp_tvalid, (rsp_tdata[OPACITY_W-1:0] <= OPACITY_ONE) && (rsp_tdata[RSP_TDATA_W-1:OPACITY_W] == '0), "opacity out of range")

endmodule

bind radial_brush_falloff_mask_unit rbfm_check u_rbfm_check (.*);

### tb/radial_brush_falloff_mask_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the radial brush falloff mask unit.
module tb;
   import rbfm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int IDX_MAX     = (1 << IDX_W) - 1;

   typedef struct packed {
      logic [OPACITY_W-1:0] opacity;
      logic                 out_of_range;
   } mask_cell_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we;
   logic [CSR_ADDR_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow copy of the configuration registers.
   logic [RADIUS_W-1:0] brush_radius;
   logic [KIND_W-1:0]   falloff_kind;

   mask_cell_type expected_cells[$];
   mask_cell_type head_cell;
   int            error_count = 0;
   int            cycle_count;
   int            stall_left;
   bit            idle_on;

   radial_brush_falloff_mask_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // Largest root with root*root <= value, found one bit at a time.
   function automatic longint unsigned floor_sqrt(input longint unsigned value);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= value) begin
            root = trial;
         end
      end
      return root;
   endfunction

   function automatic mask_cell_type predict_cell(input logic [IDX_W-1:0] cell_index);
      longint unsigned radius, side, row, col, dy, dx, dist_sq, rad_sq;
      longint unsigned dist_fx, radius_fx, gap_fx;
      mask_cell_type   pred;
      pred.opacity      = '0;
      pred.out_of_range = 1'b0;
      radius = brush_radius;
      side   = 2 * radius + 1;
      if (cell_index >= side * side) begin
         pred.out_of_range = 1'b1;
         return pred;
      end
      if (radius == 0) begin
         pred.opacity = OPACITY_ONE;
         return pred;
      end
      row     = cell_index / side;
      col     = cell_index % side;
      dy      = (row >= radius) ? row - radius : radius - row;
      dx      = (col >= radius) ? col - radius : radius - col;
      dist_sq = dy * dy + dx * dx;
      rad_sq  = radius * radius;
      if (falloff_kind == KIND_CONSTANT) begin
         pred.opacity = (dist_sq < rad_sq) ? OPACITY_ONE : '0;
      end else begin
         dist_fx   = floor_sqrt(dist_sq << 32);
         radius_fx = radius << FRAC_W;
         if (falloff_kind == KIND_LINEAR) begin
            if (dist_fx < radius_fx) begin
               pred.opacity = OPACITY_W'((radius_fx - dist_fx) / radius);
            end
         end else if (dist_sq <= rad_sq) begin
            // Selector values from quadratic upward all take the squared falloff.
            gap_fx       = radius_fx - dist_fx;
            pred.opacity = OPACITY_W'((gap_fx * gap_fx) / (rad_sq << FRAC_W));
         end
      end
      return pred;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(10, 40);
      end
      return $urandom_range(1, 3);
   endfunction

   task automatic send_request(input logic [IDX_W-1:0] cell_index);
      mask_cell_type want;
      want = predict_cell(cell_index);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(cell_index);
      do @(posedge clock); while (!req_tready);
      expected_cells.push_back(want);
   endtask

   // Stops sending and waits until every request has been answered.
   task automatic finish_burst();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_cells.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_brush(input logic [CSR_DATA_W-1:0] radius_word,
                            input logic [CSR_DATA_W-1:0] kind_word);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_BRUSH_RADIUS;
      csr_wdata <= radius_word;
      @(posedge clock);
      csr_addr  <= CSR_FALLOFF_KIND;
      csr_wdata <= kind_word;
      @(posedge clock);
      csr_we <= 1'b0;
      brush_radius = radius_word;
      falloff_kind = kind_word[KIND_W-1:0];
      @(posedge clock);
   endtask

   task automatic test_directed();
      idle_on = 1'b0;
      // Zero radius: a single cell, everything else lies outside.
      set_brush(6'd0, CSR_DATA_W'(KIND_CONSTANT));
      send_request(14'd0);
      send_request(14'd1);
      send_request(IDX_W'(IDX_MAX));
      finish_burst();
      set_brush(6'd0, CSR_DATA_W'(KIND_LINEAR));
      send_request(14'd0);
      finish_burst();
      set_brush(6'd0, CSR_DATA_W'(KIND_QUADRATIC));
      send_request(14'd0);
      finish_burst();
      // Largest radius: first cell, centre, a cell on the rim, one just inside, last cell and beyond.
      set_brush(6'd63, CSR_DATA_W'(KIND_CONSTANT));
      send_request(14'd0);
      send_request(14'd8064);
      send_request(14'd8001);
      send_request(14'd8002);
      send_request(14'd16128);
      send_request(14'd16129);
      finish_burst();
      set_brush(6'd63, CSR_DATA_W'(KIND_LINEAR));
      send_request(14'd8064);
      send_request(14'd8001);
      send_request(14'd8002);
      send_request(14'd0);
      finish_burst();
      // Selector value three with all upper write bits set.
      set_brush(6'd63, 6'b111111);
      send_request(14'd8064);
      send_request(14'd8001);
      send_request(14'd8002);
      finish_burst();
      set_brush(6'd1, CSR_DATA_W'(KIND_QUADRATIC));
      send_request(14'd0);
      send_request(14'd1);
      send_request(14'd4);
      send_request(14'd9);
      finish_burst();
   endtask

   task automatic test_random_sweep();
      logic [RADIUS_W-1:0] radius_word;
      logic [KIND_W-1:0]   kind_sel;
      int                  area;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: radius_word = 6'd63;
            1: radius_word = 6'd0;
            2: radius_word = 6'd1;
            default: radius_word = RADIUS_W'($urandom_range(0, 63));
         endcase
         kind_sel = KIND_W'(phase % 4);
         set_brush(radius_word, {4'($urandom_range(0, 15)), kind_sel});
         idle_on = (phase % 3 != 2);
         area    = (2 * radius_word + 1) * (2 * radius_word + 1);
         for (int n = 0; n < 45; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               send_request(IDX_W'($urandom_range(0, area - 1)));
            end else begin
               send_request(IDX_W'($urandom_range(0, IDX_MAX)));
            end
         end
         finish_burst();
      end
   endtask

   task automatic test_drain_pause();
      set_brush(6'd40, CSR_DATA_W'(KIND_LINEAR));
      idle_on = 1'b0;
      for (int n = 0; n < 20; n++) begin
         send_request(IDX_W'($urandom_range(0, 81 * 81 - 1)));
      end
      // The sender holds off until the pipeline has emptied, then resumes.
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_cells.size() != 0);
      idle_on = 1'b1;
      for (int n = 0; n < 20; n++) begin
         send_request(IDX_W'($urandom_range(0, 81 * 81 - 1)));
      end
      finish_burst();
   endtask

   // Result side: random stalls while idling is on.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= pick_gap() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cells.size() == 0) begin
            $display("%0t: unexpected result opacity %0d flag %0b", $time,
                     rsp_tdata[OPACITY_W-1:0], rsp_tuser);
            error_count++;
         end else begin
            head_cell = expected_cells.pop_front();
            if (rsp_tdata[OPACITY_W-1:0] !== head_cell.opacity) begin
               $display("%0t: opacity expected %0d actual %0d", $time,
                        head_cell.opacity, rsp_tdata[OPACITY_W-1:0]);
               error_count++;
            end
            if (rsp_tuser !== head_cell.out_of_range) begin
               $display("%0t: out-of-range flag expected %0b actual %0b", $time,
                        head_cell.out_of_range, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("radial_brush_falloff_mask_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      csr_we       = 1'b0;
      csr_addr     = CSR_BRUSH_RADIUS;
      csr_wdata    = '0;
      brush_radius = '0;
      falloff_kind = KIND_CONSTANT;
      idle_on      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sweep();
      test_drain_pause();
      while (expected_cells.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("radial_brush_falloff_mask_unit verification clean");
      end else begin
         $display("radial_brush_falloff_mask_unit verification failed");
      end
      $finish;
   end

endmodule
